@@ sv/gpp_pkg.sv @@
// Package for the gradient projection profile unit.
// Holds the item classification struct, register and kind codes, and the
// small arithmetic helpers used by the back part. No dependencies.
package gpp_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int QUEUE_DEPTH   = 4;
    localparam int SUM_W         = 18;
    localparam int IDX_W         = 10;
    localparam int PIX_W         = 8;
    localparam int CFG_W         = 11;
    localparam int HEIGHT_LIMIT  = 1024;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Result kinds
    localparam logic KIND_COL = 1'b0;
    localparam logic KIND_ROW = 1'b1;

    // Classification of one accepted pixel, made by the front part
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [IDX_W-1:0] row;
        logic             first_col;  // pixel opens a row
        logic             row_term;   // adds a horizontal difference
        logic             col_term;   // adds a vertical difference
        logic             col_fresh;  // second row: column sum starts over
        logic             emit_row;   // row sum is complete
        logic             emit_col;   // column sum is complete
        logic             frame_end;  // pixel is in the last column with a column sum
    } t_cls;

    function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W + 1 - PIX_W){1'b0}}, b};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

@@ sv/gpp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Used for the line store and the column sum store. No dependencies.
module gpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/gpp_front.sv @@
// Front part: configuration registers, frame position counters and pixel
// classification. Depends on gpp_pkg.
module gpp_front #(
    parameter int MAX_WIDTH = gpp_pkg::MAX_WIDTH_DEF,
    localparam int XW       = $clog2(MAX_WIDTH)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [gpp_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [gpp_pkg::PIX_W-1:0] i_pixel,
    input  logic                     i_full,
    output logic                     o_push,
    output gpp_pkg::t_cls            o_cls,
    output logic [XW-1:0]            o_x
);
    import gpp_pkg::*;

    localparam int YW = IDX_W;

    logic [XW-1:0] r_x_last, n_x_last;
    logic [XW-1:0] r_x_pre, n_x_pre;
    logic [YW-1:0] r_y_last, n_y_last;
    logic [XW-1:0] r_x, n_x;
    logic [YW-1:0] r_y, n_y;
    logic          last_col;
    logic          last_row;
    logic          accept;

    // Clamp a width to its legal range and return its last column
    function automatic logic [XW-1:0] width_last(input logic [CFG_W-1:0] v);
        int w;
        w = int'(v);
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return XW'(w - 1);
    endfunction

    // Clamp a height to its legal range and return its last row
    function automatic logic [YW-1:0] height_last(input logic [CFG_W-1:0] v);
        int h;
        h = int'(v);
        if (h < 2) h = 2;
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        return YW'(h - 1);
    endfunction

    assign accept   = i_valid && !i_full;
    assign o_ready  = !i_full;
    assign o_push   = accept;
    assign last_col = (r_x == r_x_last);
    assign last_row = (r_y == r_y_last);

    // Classify the pixel at the current position
    always_comb begin
        o_cls.pixel     = i_pixel;
        o_cls.row       = r_y;
        o_cls.first_col = (r_x == '0);
        o_cls.row_term  = (r_x != '0) && !last_row;
        o_cls.col_term  = (r_y != '0) && !last_col;
        o_cls.col_fresh = (r_y == YW'(1));
        o_cls.emit_row  = (r_x != '0) && !last_row && last_col;
        o_cls.emit_col  = (r_y != '0) && !last_col && last_row;
        o_cls.frame_end = (r_x == r_x_pre);
    end

    assign o_x = r_x;

    // Take register writes; a write restarts the frame
    always_comb begin
        n_x_last = r_x_last;
        n_x_pre  = r_x_pre;
        n_y_last = r_y_last;
        n_x      = r_x;
        n_y      = r_y;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH: begin
                    n_x_last = width_last(i_cfg_data);
                    n_x_pre  = width_last(i_cfg_data) - XW'(1);
                end
                CFG_HEIGHT: n_y_last = height_last(i_cfg_data);
                default: ;
            endcase
            n_x = '0;
            n_y = '0;
        end else if (accept) begin
            // Advance in raster order
            if (last_col) begin
                n_x = '0;
                n_y = last_row ? '0 : r_y + YW'(1);
            end else begin
                n_x = r_x + XW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_last <= width_last(CFG_W'(1024));
            r_x_pre  <= width_last(CFG_W'(1024)) - XW'(1);
            r_y_last <= height_last(CFG_W'(1024));
            r_x      <= '0;
            r_y      <= '0;
        end else begin
            r_x_last <= n_x_last;
            r_x_pre  <= n_x_pre;
            r_y_last <= n_y_last;
            r_x      <= n_x;
            r_y      <= n_y;
        end
    end

endmodule

@@ sv/gpp_queue.sv @@
// Short request queue between the front and back parts.
// Register-based FIFO with a registered fill count. No dependencies.
module gpp_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    // Move pointers and count
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

@@ sv/gpp_back.sv @@
// Back part: reads the line and column stores, forms the difference sums,
// writes the stores back and holds the result register. Depends on gpp_pkg
// and gpp_ram.
module gpp_back #(
    parameter int MAX_WIDTH = gpp_pkg::MAX_WIDTH_DEF,
    localparam int XW       = $clog2(MAX_WIDTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    output logic                      o_pop,
    input  gpp_pkg::t_cls             i_cls,
    input  logic [XW-1:0]             i_x,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_kind,
    output logic [gpp_pkg::IDX_W-1:0] o_index,
    output logic [gpp_pkg::SUM_W-1:0] o_value,
    output logic                      o_last
);
    import gpp_pkg::*;

    localparam int XPW = (XW > IDX_W) ? XW : IDX_W;

    t_cls             r_cls;
    logic [XW-1:0]    r_xa;
    logic             r_busy;
    logic             adv;
    logic             emit;
    logic [PIX_W-1:0] line_rd;
    logic [SUM_W-1:0] col_rd;
    logic [PIX_W-1:0] col_diff;
    logic [SUM_W-1:0] col_new;
    logic [PIX_W-1:0] row_diff;
    logic [SUM_W-1:0] row_new;
    logic [XPW-1:0]   x_wide;
    logic [SUM_W-1:0] r_acc;
    logic [PIX_W-1:0] r_left;
    logic             r_out_valid;
    logic             r_kind;
    logic [IDX_W-1:0] r_index;
    logic [SUM_W-1:0] r_value;
    logic             r_last;

    // Stage advances unless its result finds the output register full and stalled
    assign emit  = r_cls.emit_row || r_cls.emit_col;
    assign adv   = r_busy && (!emit || !r_out_valid || i_ready);
    assign o_pop = !i_empty && (!r_busy || adv);

    gpp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line (
        .i_clk   (i_clk),
        .i_we    (adv),
        .i_waddr (r_xa),
        .i_wdata (r_cls.pixel),
        .i_re    (o_pop),
        .i_raddr (i_x),
        .o_rdata (line_rd)
    );

    gpp_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WIDTH)) u_colsum (
        .i_clk   (i_clk),
        .i_we    (adv && r_cls.col_term),
        .i_waddr (r_xa),
        .i_wdata (col_new),
        .i_re    (o_pop),
        .i_raddr (i_x),
        .o_rdata (col_rd)
    );

    // Vertical and horizontal difference terms
    assign col_diff = absdiff(line_rd, r_cls.pixel);
    assign col_new  = r_cls.col_fresh ? {{(SUM_W - PIX_W){1'b0}}, col_diff}
                                      : sat_add(col_rd, col_diff);
    assign row_diff = absdiff(r_left, r_cls.pixel);
    assign row_new  = sat_add(r_acc, row_diff);
    assign x_wide   = XPW'(r_xa);

    // Hold the request whose store reads are in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (adv) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cls <= i_cls;
            r_xa  <= i_x;
        end
    end

    // Row accumulator and left neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_left <= '0;
        end else if (adv) begin
            r_left <= r_cls.pixel;
            if (r_cls.first_col) begin
                r_acc <= '0;
            end else if (r_cls.row_term) begin
                r_acc <= row_new;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_kind  <= r_cls.emit_row ? KIND_ROW : KIND_COL;
            r_index <= r_cls.emit_row ? r_cls.row : x_wide[IDX_W-1:0];
            r_value <= r_cls.emit_row ? row_new : col_new;
            r_last  <= r_cls.emit_col && r_cls.frame_end;
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_kind;
    assign o_index = r_index;
    assign o_value = r_value;
    assign o_last  = r_last;

endmodule

@@ sv/gradient_projection_profile_unit.sv @@
// Top level of the gradient projection profile unit: front, request queue
// and back. Depends on gpp_pkg, gpp_front, gpp_queue, gpp_back.
//
//  Channel   Dir  Handshake                 Payload
//  s_axis    in   tvalid/tready             tdata[7:0] pixel
//  m_axis    out  tvalid/tready             tdata: sum_index, sum_value;
//                                           tuser sum_kind; tlast last_of_frame
//  cfg       in   we (no wait, no readback) index 0 width, 1 height; data[10:0]
//
// One pixel per cycle sustained while the output is not stalled; the column
// store's single read-modify-write per cycle sets that figure. An accepted pixel
// is pushed into the queue; a pop reads the stores, and the back part then forms
// the sum into the output register.
// Reset is synchronous; the line and column stores need no clearing pass,
// since each entry is written in a frame before it is read.
// A stalled output backs up through the back part into the four-entry queue;
// the input keeps accepting until the queue is full.
module gradient_projection_profile_unit #(
    parameter int MAX_WIDTH = gpp_pkg::MAX_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [7:0]                i_s_axis_tdata,   // [7:0] pixel
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [31:0]               o_m_axis_tdata,   // [9:0] sum_index,
                                                        // [27:10] sum_value, [31:28] zero
    output logic                      o_m_axis_tuser,   // [0] sum_kind
    output logic                      o_m_axis_tlast,   // last_of_frame
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [gpp_pkg::CFG_W-1:0] i_cfg_data
);
    import gpp_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int QW = $bits(t_cls) + XW;

    t_cls             front_cls;
    t_cls             back_cls;
    logic [XW-1:0]    front_x;
    logic [XW-1:0]    back_x;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    logic [QW-1:0]    q_out;
    logic [IDX_W-1:0] sum_index;
    logic [SUM_W-1:0] sum_value;

    gpp_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_pixel     (i_s_axis_tdata),
        .i_full      (full),
        .o_push      (push),
        .o_cls       (front_cls),
        .o_x         (front_x)
    );

    gpp_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_cls, front_x}),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (empty)
    );

    assign back_cls = q_out[QW-1:XW];
    assign back_x   = q_out[XW-1:0];

    gpp_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .o_pop   (pop),
        .i_cls   (back_cls),
        .i_x     (back_x),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_kind  (o_m_axis_tuser),
        .o_index (sum_index),
        .o_value (sum_value),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {4'b0000, sum_value, sum_index};

endmodule

@@ sv/gpp_checker.sv @@
// Port-level checks for the gradient projection profile unit, bound to the
// top level. Depends on the top level's port list only.
module gpp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // Drop output valid after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // Hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // Keep the padding of tdata at zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[31:28] == 4'b0000))
        else $error("tdata padding not zero");

    // Mark frame end only on a column sum
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> !o_m_axis_tuser)
        else $error("frame end on a row sum");

endmodule

bind gradient_projection_profile_unit gpp_checker u_gpp_checker (.*);

@@ tb/sv/tb_gradient_projection_profile_unit.sv @@
`timescale 1ns / 100ps
// Testbench for gradient_projection_profile_unit: streams gray frames through the
// block and checks every row and column sum against a cycle-free model of the
// profile. Depends on gpp_pkg and the block's RTL.
module tb_gradient_projection_profile_unit;
    import gpp_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 16;

    typedef enum {FILL_NOISE, FILL_CHECKER, FILL_FLAT} t_fill;

    typedef struct {
        logic             kind;
        logic [IDX_W-1:0] index;
        logic [SUM_W-1:0] value;
        logic             frame_end;
    } t_profile_sum;

    // Clamp a written size to the range the block uses
    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned top);
        return (v < 2) ? 2 : (v > top) ? top : v;
    endfunction

    // Running profile of the frame and the sums still owed by the block
    class t_gradient_sums;
        int unsigned      width_reg;
        int unsigned      height_reg;
        logic [PIX_W-1:0] prev_row [MAX_WIDTH_DEF];
        logic [SUM_W-1:0] col_total [MAX_WIDTH_DEF];
        logic [SUM_W-1:0] row_total;
        logic [PIX_W-1:0] left_pix;
        int unsigned      col_at;
        int unsigned      row_at;
        t_profile_sum     pending_sums[$];
        int unsigned      errors;
        int unsigned      pixels_taken;
        int unsigned      rows_checked;
        int unsigned      cols_checked;
        int unsigned      frames_closed;

        function new();
            width_reg  = MAX_WIDTH_DEF;
            height_reg = HEIGHT_LIMIT;
            restart();
        endfunction

        function void restart();
            row_total = '0;
            left_pix  = '0;
            col_at    = 0;
            row_at    = 0;
        endfunction

        // Any register write starts a new frame
        function void write_reg(input logic idx, input logic [CFG_W-1:0] val);
            if (idx == CFG_WIDTH) width_reg = val;
            else height_reg = val;
            restart();
        endfunction

        function logic [SUM_W-1:0] add_clip(input logic [SUM_W-1:0] a, input int unsigned b);
            int unsigned s;
            s = a + b;
            return (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
        endfunction

        // Append a sum to the list the block still owes
        function void note_owed(input t_profile_sum s);
            pending_sums.insert(pending_sums.size(), s);
        endfunction

        function void take_pixel(input logic [PIX_W-1:0] p);
            int unsigned  w;
            int unsigned  h;
            int unsigned  x;
            int unsigned  y;
            int unsigned  step;
            t_profile_sum s;
            w = clamp_size(width_reg, MAX_WIDTH_DEF);
            h = clamp_size(height_reg, HEIGHT_LIMIT);
            pixels_taken++;
            if (col_at >= w || row_at >= h) restart();
            x = col_at;
            y = row_at;

            // Horizontal differences along the row; emit on its final term
            if (x == 0) begin
                row_total = '0;
            end else if (y + 1 < h) begin
                step = (left_pix > p) ? left_pix - p : p - left_pix;
                row_total = add_clip(row_total, step);
                if (x == w - 1) begin
                    s.kind      = KIND_ROW;
                    s.index     = y[IDX_W-1:0];
                    s.value     = row_total;
                    s.frame_end = 1'b0;
                    note_owed(s);
                end
            end

            // Vertical differences against the previous row; emit on the last row
            if (y >= 1 && x + 1 < w) begin
                step = (prev_row[x] > p) ? prev_row[x] - p : p - prev_row[x];
                col_total[x] = (y == 1) ? step[SUM_W-1:0] : add_clip(col_total[x], step);
                if (y == h - 1) begin
                    s.kind      = KIND_COL;
                    s.index     = x[IDX_W-1:0];
                    s.value     = col_total[x];
                    s.frame_end = (x == w - 2);
                    note_owed(s);
                    if (s.frame_end) frames_closed++;
                end
            end

            prev_row[x] = p;
            left_pix    = p;

            // Advance the raster position
            if (x + 1 < w) begin
                col_at = x + 1;
            end else begin
                col_at = 0;
                row_at = (y + 1 < h) ? y + 1 : 0;
            end
        endfunction

        function void compare(input string name, input int unsigned exp, input logic [31:0] act);
            if (act !== exp) begin
                $error("%s: expected %0d, got %0d", name, exp, act);
                errors++;
            end
        endfunction

        function void match_sum(input logic kind, input logic [IDX_W-1:0] index,
                                input logic [SUM_W-1:0] value, input logic frame_end);
            t_profile_sum e;
            if (pending_sums.size() == 0) begin
                $error("sum with none owed: kind %0d index %0d value %0d", kind, index, value);
                errors++;
                return;
            end
            e = pending_sums.pop_front();
            compare("sum_kind", e.kind, kind);
            compare("sum_index", e.index, index);
            compare("sum_value", e.value, value);
            compare("last_of_frame", e.frame_end, frame_end);
            if (e.kind == KIND_ROW) rows_checked++;
            else cols_checked++;
        endfunction

        function void close_out();
            if (pending_sums.size() != 0) begin
                $error("%0d sums never arrived", pending_sums.size());
                errors += pending_sums.size();
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [7:0]         i_s_axis_tdata = '0;      // [7:0] pixel
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [31:0]        o_m_axis_tdata;           // [9:0] sum_index, [27:10] sum_value
    logic               o_m_axis_tuser;           // [0] sum_kind
    logic               o_m_axis_tlast;           // last_of_frame
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = CFG_WIDTH;
    logic [CFG_W-1:0]   i_cfg_data = '0;

    t_gradient_sums sums = new();
    int unsigned    burst_left = 0;
    int unsigned    settings_used = 0;

    gradient_projection_profile_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // Track accepted pixels, register writes and results
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_we) sums.write_reg(i_cfg_index, i_cfg_data);
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) sums.take_pixel(i_s_axis_tdata);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sums.match_sum(o_m_axis_tuser, o_m_axis_tdata[IDX_W-1:0],
                           o_m_axis_tdata[IDX_W +: SUM_W], o_m_axis_tlast);
    end

    // Receiver: switch at random among five stall patterns
    int unsigned cycle_no = 0;
    int unsigned stall_mode = 0;
    always @(posedge i_clk) begin
        cycle_no++;
        if (cycle_no % 256 == 0) stall_mode = $urandom_range(0, 4);
        case (stall_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= $urandom_range(0, 1);
            2: i_m_axis_tready <= ($urandom_range(0, 9) != 0);
            3: i_m_axis_tready <= (cycle_no % 7) < 3;
            default: i_m_axis_tready <= (cycle_no % 64) >= 24;
        endcase
    end

    // Send one pixel request; hold valid through a burst, drop it for a gap
    task automatic send_pixel(input logic [PIX_W-1:0] value, input bit stop);
        int unsigned gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        gap = 0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                      : $urandom_range(1, 12);
        end
        if (stop || gap != 0) i_s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    // Write both size registers in random order
    task automatic program_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        bit height_first;
        height_first = $urandom_range(0, 1);
        settings_used++;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= height_first ? CFG_HEIGHT : CFG_WIDTH;
        i_cfg_data  <= height_first ? h : w;
        @(posedge i_clk);
        i_cfg_index <= height_first ? CFG_WIDTH : CFG_HEIGHT;
        i_cfg_data  <= height_first ? w : h;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Wait until every owed sum is back, then let the pipeline settle
    task automatic wait_drained();
        @(posedge i_clk);
        while (sums.pending_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Stream n pixels of a pattern over a frame of width w, then drain
    task automatic stream_pixels(input int unsigned n, input int unsigned w,
                                 input int unsigned h, input t_fill fill);
        logic [PIX_W-1:0] level;
        logic [PIX_W-1:0] p;
        int unsigned      x;
        int unsigned      y;
        level = $urandom_range(0, 255);
        for (int unsigned i = 0; i < n; i++) begin
            x = i % w;
            y = (i / w) % h;
            case (fill)
                FILL_CHECKER: p = ((x + y) % 2 != 0) ? 8'hFF : 8'h00;
                FILL_FLAT:    p = level;
                default:      p = $urandom_range(0, 255);
            endcase
            send_pixel(p, i == n - 1);
        end
        wait_drained();
    endtask

    initial begin
        logic [PIX_W-1:0] edge_frame [9];
        logic [PIX_W-1:0] tiny_frame [4];
        int unsigned      random_pixels;
        int unsigned      r;
        int unsigned      w_cfg;
        int unsigned      h_cfg;
        int unsigned      w_used;
        int unsigned      h_used;
        int unsigned      n;
        t_fill            fill;

        edge_frame = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd128};
        tiny_frame = '{8'd255, 8'd0, 8'd0, 8'd255};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: 3x3 frame with extreme pixels
        program_frame(3, 3);
        foreach (edge_frame[i]) send_pixel(edge_frame[i], i == 8);
        wait_drained();

        // Directed: sizes below range clamp to a 2x2 frame
        program_frame(0, 1);
        foreach (tiny_frame[i]) send_pixel(tiny_frame[i], i == 3);
        wait_drained();

        // Directed: cut a 4x3 frame short, then restart it with a fresh write
        program_frame(4, 3);
        stream_pixels(5, 4, 3, FILL_NOISE);
        program_frame(4, 3);
        stream_pixels(12, 4, 3, FILL_NOISE);

        // Widest and tallest settings, clamped from above, at full contrast;
        // the widest takes a full row plus a few column sums, the tallest a few rows
        program_frame(2047, 2);
        stream_pixels(MAX_WIDTH_DEF + 8, MAX_WIDTH_DEF, 2, FILL_CHECKER);
        program_frame(2, 2047);
        stream_pixels(40, 2, HEIGHT_LIMIT, FILL_CHECKER);

        // Random settings: mostly whole small frames, some cut short
        random_pixels = 0;
        while (random_pixels < 500) begin
            r = $urandom_range(0, 99);
            if (r < 80) w_cfg = $urandom_range(2, 12);
            else if (r < 88) w_cfg = $urandom_range(0, 1);
            else if (r < 95) w_cfg = $urandom_range(13, 64);
            else w_cfg = $urandom_range(1000, 2047);
            w_used = clamp_size(w_cfg, MAX_WIDTH_DEF);

            r = $urandom_range(0, 99);
            if (w_used > 64) h_cfg = $urandom_range(0, 3);
            else if (r < 80) h_cfg = $urandom_range(2, 10);
            else if (r < 90) h_cfg = $urandom_range(0, 1);
            else if (r < 97 || w_used > 2) h_cfg = $urandom_range(11, 40);
            else h_cfg = $urandom_range(1000, 2047);
            h_used = clamp_size(h_cfg, HEIGHT_LIMIT);

            // Large frames get only a short opening stretch
            if (w_used * h_used > 256) begin
                n = $urandom_range(8, 64);
            end else begin
                n = $urandom_range(1, 3) * w_used * h_used;
                if ($urandom_range(0, 6) == 0) n = n - $urandom_range(1, w_used * h_used - 1);
            end

            r = $urandom_range(0, 9);
            fill = (r == 0) ? FILL_CHECKER : (r == 1) ? FILL_FLAT : FILL_NOISE;

            program_frame(w_cfg, h_cfg);
            stream_pixels(n, w_used, h_used, fill);
            random_pixels += n;
        end

        wait_drained();
        sums.close_out();
        $display("covered %0d pixels over %0d size settings, %0d frames closed",
                 sums.pixels_taken, settings_used, sums.frames_closed);
        $display("checked %0d row sums and %0d column sums",
                 sums.rows_checked, sums.cols_checked);
        if (sums.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
sv/gpp_pkg.sv
sv/gpp_ram.sv
sv/gpp_front.sv
sv/gpp_queue.sv
sv/gpp_back.sv
sv/gradient_projection_profile_unit.sv
sv/gpp_checker.sv
tb/sv/tb_gradient_projection_profile_unit.sv
